/* rtl/core/tps_pkg.sv */
// Shared constants, codes and control types of the trigger pattern sequencer.
package tps_pkg;

	localparam int MAX_TRIGS = 16;
	localparam int IDX_W = (MAX_TRIGS > 1) ? $clog2(MAX_TRIGS) : 1;
	localparam int NEXT_W = $clog2(MAX_TRIGS + 1);

	localparam int POS_W = 16;
	localparam int CMD_W = 2;
	localparam int SLOT_W = 4;
	localparam int TRIG_INDEX_W = 4;
	localparam int MODE_W = 2;
	localparam int COUNT_W = 5;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 5;

	localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RESET_EVT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;

	localparam logic [MODE_W-1:0] MODE_RESTART = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ONE_SHOT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RESTART_RUN = 2'd2;
	localparam logic [MODE_W-1:0] MODE_RUN_WHILE_HIGH = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_RESET_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TRIG_COUNT = 1'd1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic in_ready;
		logic accept;
		logic step;
		logic busy;
	} tps_ctrl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic load_ok;
		logic go_walk;
		logic hit;
	} tps_status_t;

endpackage

/* rtl/core/tps_if.sv */
// Valid/ready channel interfaces for the sequencer input items and results.
interface tps_req_if
	import tps_pkg::*;
();
	logic valid;
	logic ready;
	logic [CMD_W-1:0] cmd;
	logic [POS_W-1:0] position;
	logic restart_flag;
	logic reset_level;
	logic [SLOT_W-1:0] slot;

	modport source (output valid, output cmd, output position, output restart_flag,
		output reset_level, output slot, input ready);
	modport sink (input valid, input cmd, input position, input restart_flag,
		input reset_level, input slot, output ready);
endinterface

interface tps_rsp_if
	import tps_pkg::*;
();
	logic valid;
	logic ready;
	logic fire;
	logic [TRIG_INDEX_W-1:0] trig_index;
	logic restart_request;
	logic last;

	modport source (output valid, output fire, output trig_index, output restart_request,
		output last, input ready);
	modport sink (input valid, input fire, input trig_index, input restart_request,
		input last, output ready);
endinterface

/* rtl/core/trigger_pattern_sequencer.sv */
// Timing: a reset event, table write, restart tick or unknown command loads its result at
// the transfer edge, so it is offered in the next cycle; such items can follow back to back
// when the receiver keeps up. A tick walks the table one entry per cycle when the receiver
// keeps up, plus a final step that ends the walk; one item is in work at a time, so the next
// input transfer waits until the walk of a tick ends, and receiver stalls stretch the walk.
// Reset clears the index, last position and configuration and sets output enable and the
// held reset level; the trigger table is not cleared and must be written before use.
module trigger_pattern_sequencer
	import tps_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	tps_req_if.sink               req,
	tps_rsp_if.source             rsp
);

	tps_ctrl_t   ctrl;
	tps_status_t status;

	assign req.ready = ctrl.in_ready;

	tps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.status   (status),
		.ctrl     (ctrl)
	);

	tps_datapath u_datapath (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_index           (cfg_index),
		.cfg_wdata           (cfg_wdata),
		.cmd                 (req.cmd),
		.position            (req.position),
		.restart_flag        (req.restart_flag),
		.reset_level         (req.reset_level),
		.slot                (req.slot),
		.ctrl                (ctrl),
		.status              (status),
		.rsp_valid           (rsp.valid),
		.rsp_ready           (rsp.ready),
		.rsp_fire            (rsp.fire),
		.rsp_trig_index      (rsp.trig_index),
		.rsp_restart_request (rsp.restart_request),
		.rsp_last            (rsp.last)
	);

	a_accept_step_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.accept && ctrl.step))
		else $error("accept and walk step in the same cycle");

	a_walk_ends: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.step && !status.hit |=> !ctrl.busy)
		else $error("walk did not end after a miss");

	a_no_transfer_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |-> !ctrl.busy)
		else $error("input transfer during a walk");

	a_rq_not_fire: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.restart_request |-> !rsp.fire && rsp.last)
		else $error("restart request on a fire or non-final result");

endmodule

/* rtl/core/tps_ctrl.sv */
// Controller state machine: input acceptance and the table walk of a tick.
module tps_ctrl
	import tps_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  tps_status_t status,
	output tps_ctrl_t   ctrl
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_WALK = 1'b1;

	logic state_q;
	logic state_d;

	always_comb begin
		ctrl.in_ready = (state_q == ST_IDLE) && status.load_ok;
		ctrl.accept = in_valid && ctrl.in_ready;
		ctrl.step = (state_q == ST_WALK) && status.load_ok;
		ctrl.busy = (state_q == ST_WALK);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (ctrl.accept && status.go_walk) state_d = ST_WALK;
			end
			ST_WALK: begin
				if (ctrl.step && !status.hit) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/core/tps_datapath.sv */
// Datapath: trigger table, sequencing state, configuration and result register.
module tps_datapath
	import tps_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_wdata,
	input  logic [CMD_W-1:0]        cmd,
	input  logic [POS_W-1:0]        position,
	input  logic                    restart_flag,
	input  logic                    reset_level,
	input  logic [SLOT_W-1:0]       slot,
	input  tps_ctrl_t               ctrl,
	output tps_status_t             status,
	output logic                    rsp_valid,
	input  logic                    rsp_ready,
	output logic                    rsp_fire,
	output logic [TRIG_INDEX_W-1:0] rsp_trig_index,
	output logic                    rsp_restart_request,
	output logic                    rsp_last
);

	logic [POS_W-1:0]  trig_table_q [MAX_TRIGS];
	logic [NEXT_W-1:0] next_trig_q;
	logic [POS_W-1:0]  last_position_q;
	logic              level_held_q;
	logic              output_enable_q;
	logic [MODE_W-1:0] reset_mode_q;
	logic [COUNT_W-1:0] trig_count_q;

	logic [POS_W-1:0]  pos_q;
	logic              wrap_q;
	logic              have_pend_q;
	logic [IDX_W-1:0]  pend_idx_q;

	logic              out_valid_q;
	logic              out_fire_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic              out_rq_q;
	logic              out_last_q;

	logic [NEXT_W-1:0] eff_count;
	logic [IDX_W-1:0]  cur_idx;
	logic              in_range;
	logic              hit;
	logic              emit;
	logic              emit_fire;
	logic [IDX_W-1:0]  emit_idx;
	logic              emit_rq;
	logic              emit_last;

	always_comb begin
		if (int'(trig_count_q) > MAX_TRIGS) eff_count = NEXT_W'(MAX_TRIGS);
		else eff_count = NEXT_W'(trig_count_q);
		cur_idx = next_trig_q[IDX_W-1:0];
		in_range = next_trig_q < eff_count;
		// On a wrap every remaining entry fires, but only with output enabled.
		hit = in_range && (wrap_q ? output_enable_q : (trig_table_q[cur_idx] <= pos_q));
	end

	always_comb begin
		status.load_ok = !out_valid_q || rsp_ready;
		status.go_walk = (cmd == CMD_TICK) && !restart_flag;
		status.hit = hit;
	end

	// Result to load into the output register this cycle, if any.
	always_comb begin
		emit = 1'b0;
		emit_fire = 1'b0;
		emit_idx = '0;
		emit_rq = 1'b0;
		emit_last = 1'b1;
		if (ctrl.accept) begin
			if (cmd == CMD_TICK) begin
				emit = restart_flag;
			end else begin
				emit = 1'b1;
				if (cmd == CMD_RESET_EVT) emit_rq = reset_level && (reset_mode_q != MODE_RUN_WHILE_HIGH);
			end
		end else if (ctrl.step) begin
			if (hit) begin
				// A held fire is known not to be final once another entry fires.
				emit = have_pend_q && output_enable_q;
				emit_fire = 1'b1;
				emit_idx = pend_idx_q;
				emit_last = 1'b0;
			end else begin
				emit = 1'b1;
				emit_fire = have_pend_q;
				emit_idx = have_pend_q ? pend_idx_q : '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.accept && cmd == CMD_WRITE && int'(slot) < MAX_TRIGS) begin
			trig_table_q[IDX_W'(slot)] <= position;
		end
		if (ctrl.accept && cmd == CMD_TICK) begin
			pos_q <= position;
			wrap_q <= position < last_position_q;
		end
		if (ctrl.step && hit) pend_idx_q <= cur_idx;
		if (emit) begin
			out_fire_q <= emit_fire;
			out_idx_q <= emit_idx;
			out_rq_q <= emit_rq;
			out_last_q <= emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_trig_q <= '0;
			last_position_q <= '0;
			level_held_q <= 1'b1;
			output_enable_q <= 1'b1;
			reset_mode_q <= MODE_RESTART;
			trig_count_q <= '0;
			have_pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_RESET_MODE: begin
						reset_mode_q <= cfg_wdata[MODE_W-1:0];
						if (cfg_wdata[MODE_W-1:0] == MODE_RESTART_RUN ||
							cfg_wdata[MODE_W-1:0] == MODE_RUN_WHILE_HIGH) begin
							output_enable_q <= level_held_q;
						end
					end
					CFG_TRIG_COUNT: trig_count_q <= cfg_wdata[COUNT_W-1:0];
					default: ;
				endcase
			end
			if (ctrl.accept) begin
				if (cmd == CMD_TICK) begin
					last_position_q <= position;
					have_pend_q <= 1'b0;
					if (restart_flag) next_trig_q <= '0;
				end else if (cmd == CMD_RESET_EVT) begin
					level_held_q <= reset_level;
					if (reset_level) begin
						output_enable_q <= 1'b1;
					end else if (reset_mode_q == MODE_RESTART_RUN ||
						reset_mode_q == MODE_RUN_WHILE_HIGH) begin
						output_enable_q <= 1'b0;
					end
				end
			end else if (ctrl.step) begin
				if (hit) begin
					next_trig_q <= next_trig_q + NEXT_W'(1);
					if (output_enable_q) have_pend_q <= 1'b1;
				end else begin
					have_pend_q <= 1'b0;
					if (wrap_q) next_trig_q <= '0;
				end
			end
			if (emit) out_valid_q <= 1'b1;
			else if (rsp_ready) out_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_fire = out_fire_q;
	assign rsp_trig_index = TRIG_INDEX_W'(out_idx_q);
	assign rsp_restart_request = out_rq_q;
	assign rsp_last = out_last_q;

endmodule

/* bench/trigger_pattern_sequencer_tb.sv */
// Self-checking bench for the trigger pattern sequencer against a predictor.
module trigger_pattern_sequencer_tb
	import tps_pkg::*;
();

	localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int DRAIN_MARGIN = 2 * (MAX_TRIGS + 1);
	localparam int NUM_PHASES = 8;
	localparam int PHASE_ITEMS = 54;
	localparam int POS_SPAN = 1 << POS_W;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [POS_W-1:0] position;
		logic restart_flag;
		logic reset_level;
		logic [SLOT_W-1:0] slot;
	} seq_cmd_t;

	typedef struct packed {
		logic fire;
		logic [TRIG_INDEX_W-1:0] trig_index;
		logic restart_request;
		logic last;
	} pulse_t;

	class trigger_scoreboard;
		logic [POS_W-1:0] pattern_pos [MAX_TRIGS];
		int unsigned next_idx = 0;
		logic [POS_W-1:0] last_tick_pos = '0;
		logic level_held = 1'b1;
		logic out_en = 1'b1;
		logic [MODE_W-1:0] mode = MODE_RESTART;
		logic [COUNT_W-1:0] count_reg = '0;
		pulse_t pending_pulses[$];
		int cmd_seen [4];
		int results_checked = 0;
		int pulses_checked = 0;
		int restarts_checked = 0;
		int mismatches = 0;

		function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == CFG_RESET_MODE) begin
				mode = data[MODE_W-1:0];
				// The run-while-high modes pick up the reset level seen so far.
				if (mode == MODE_RESTART_RUN || mode == MODE_RUN_WHILE_HIGH)
					out_en = level_held;
			end else if (idx == CFG_TRIG_COUNT) begin
				count_reg = data[COUNT_W-1:0];
			end
		endfunction

		function void note_item(seq_cmd_t c);
			pulse_t burst [MAX_TRIGS + 1];
			int n;
			int unsigned span;
			n = 0;
			span = (count_reg > MAX_TRIGS) ? MAX_TRIGS : count_reg;
			cmd_seen[c.cmd]++;
			case (c.cmd)
				CMD_TICK: begin
					if (c.restart_flag) begin
						next_idx = 0;
					end else if (c.position < last_tick_pos) begin
						// The pattern cycle wrapped: with output enabled flush what is left, then rewind.
						if (out_en) begin
							while (next_idx < span) begin
								burst[n] = '{1'b1, next_idx[TRIG_INDEX_W-1:0], 1'b0, 1'b0};
								n++;
								next_idx++;
							end
						end
						next_idx = 0;
					end else begin
						while (next_idx < span && pattern_pos[next_idx] <= c.position) begin
							if (out_en) begin
								burst[n] = '{1'b1, next_idx[TRIG_INDEX_W-1:0], 1'b0, 1'b0};
								n++;
							end
							next_idx++;
						end
					end
					last_tick_pos = c.position;
				end
				CMD_RESET_EVT: begin
					level_held = c.reset_level;
					burst[0] = '0;
					if (c.reset_level) begin
						out_en = 1'b1;
						burst[0].restart_request = (mode != MODE_RUN_WHILE_HIGH);
					end else if (mode == MODE_RESTART_RUN || mode == MODE_RUN_WHILE_HIGH) begin
						out_en = 1'b0;
					end
					n = 1;
				end
				CMD_WRITE: begin
					pattern_pos[c.slot] = c.position;
					burst[0] = '0;
					n = 1;
				end
				default: ;
			endcase
			if (n == 0) begin
				burst[0] = '0;
				n = 1;
			end
			burst[n - 1].last = 1'b1;
			for (int k = 0; k < n; k++)
				pending_pulses.push_back(burst[k]);
		endfunction

		function void check_pulse(pulse_t got);
			pulse_t want;
			results_checked++;
			if (got.fire === 1'b1)
				pulses_checked++;
			if (got.restart_request === 1'b1)
				restarts_checked++;
			if (pending_pulses.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result: fire=%b index=%0d restart=%b last=%b",
						got.fire, got.trig_index, got.restart_request, got.last);
				return;
			end
			want = pending_pulses.pop_front();
			if (got.fire !== want.fire || got.trig_index !== want.trig_index ||
					got.restart_request !== want.restart_request || got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Mismatch: want f=%b i=%0d r=%b l=%b, got f=%b i=%0d r=%b l=%b",
						want.fire, want.trig_index, want.restart_request, want.last,
						got.fire, got.trig_index, got.restart_request, got.last);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_request = 0;
	int clock_pos = 0;
	trigger_scoreboard sb = new();

	tps_req_if req_ch();
	tps_rsp_if rsp_ch();

	trigger_pattern_sequencer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
			input logic rflag, input logic level, input logic [SLOT_W-1:0] slot);
		int gap;
		seq_cmd_t item;
		gap = 0;
		while (gap < 12 && $urandom_range(0, 99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.cmd <= cmd;
		req_ch.position <= pos;
		req_ch.restart_flag <= rflag;
		req_ch.reset_level <= level;
		req_ch.slot <= slot;
		@(posedge clk);
		while (req_ch.ready !== 1'b1)
			@(posedge clk);
		item = '{cmd, pos, rflag, level, slot};
		sb.note_item(item);
	endtask

	task automatic send_tick(input logic [POS_W-1:0] pos, input logic rflag);
		send_item(CMD_TICK, pos, rflag, 1'($urandom_range(0, 1)),
			SLOT_W'($urandom_range(0, 15)));
	endtask

	task automatic send_level(input logic level);
		send_item(CMD_RESET_EVT, POS_W'($urandom_range(0, POS_SPAN - 1)),
			1'($urandom_range(0, 1)), level, SLOT_W'($urandom_range(0, 15)));
	endtask

	task automatic drain_results();
		req_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending_pulses.size() != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		sb.apply_register(idx, data);
	endtask

	// Registers change only with nothing in flight.
	task automatic configure(input logic [MODE_W-1:0] mode, input logic [COUNT_W-1:0] count);
		logic [CFG_DATA_W-1:0] mode_word;
		drain_results();
		mode_word = CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1));
		mode_word[MODE_W-1:0] = mode;
		write_reg(CFG_RESET_MODE, mode_word);
		write_reg(CFG_TRIG_COUNT, CFG_DATA_W'(count));
		cfg_we <= 1'b0;
	endtask

	// Writes every slot with a non-decreasing set of trigger positions.
	task automatic load_pattern();
		int p;
		int stride;
		p = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3000);
		stride = $urandom_range(200, 8500);
		for (int s = 0; s < MAX_TRIGS; s++) begin
			send_item(CMD_WRITE, p[POS_W-1:0], 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), s[SLOT_W-1:0]);
			p = p + $urandom_range(0, stride);
			if (p > POS_SPAN - 1)
				p = POS_SPAN - 1;
		end
	endtask

	// Clock positions that mostly move forward, with wraps and restarts mixed in.
	task automatic send_pattern_tick();
		int r;
		int p;
		r = $urandom_range(0, 99);
		if (r < 6) begin
			p = $urandom_range(0, 2000);
			send_tick(p[POS_W-1:0], 1'b1);
		end else begin
			if (r < 12)
				p = $urandom_range(0, clock_pos);
			else if (r < 22)
				p = (clock_pos + $urandom_range(0, 40000)) % POS_SPAN;
			else
				p = (clock_pos + $urandom_range(0, 3000)) % POS_SPAN;
			send_tick(p[POS_W-1:0], 1'b0);
		end
		clock_pos = p;
	endtask

	// Result side: check every transfer, then pick the ready level for the next cycle.
	initial begin
		pulse_t got;
		int hold_left;
		hold_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				got = '{rsp_ch.fire, rsp_ch.trig_index, rsp_ch.restart_request, rsp_ch.last};
				sb.check_pulse(got);
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (hold_request > 0) begin
				hold_left = hold_request - 1;
				hold_request = 0;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
					(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("Watchdog: no transfer for %0d cycles, %0d results pending",
			WATCHDOG_LIMIT, sb.pending_pulses.size());
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		logic [MODE_W-1:0] phase_mode [NUM_PHASES];
		int phase_count [NUM_PHASES];
		int send_profile [4];
		int recv_profile [4];
		int sent;
		int r;
		bit paused;

		phase_mode = '{MODE_RESTART, MODE_ONE_SHOT, MODE_RESTART_RUN, MODE_RUN_WHILE_HIGH,
			MODE_RUN_WHILE_HIGH, MODE_RESTART_RUN, MODE_RESTART, MODE_ONE_SHOT};
		phase_count = '{16, 0, 17, 9, 31, 1, 16, 12};
		send_profile = '{0, 66, 0, 22};
		recv_profile = '{0, 0, 66, 22};

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_RESET_MODE;
		cfg_wdata <= '0;
		req_ch.valid <= 1'b0;
		req_ch.cmd <= CMD_TICK;
		req_ch.position <= '0;
		req_ch.restart_flag <= 1'b0;
		req_ch.reset_level <= 1'b0;
		req_ch.slot <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Evenly spaced table from 0 up to the top position, so that every read is defined.
		for (int s = MAX_TRIGS - 1; s >= 0; s--)
			send_item(CMD_WRITE, POS_W'(s * 4369), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), s[SLOT_W-1:0]);
		send_tick(16'd0, 1'b0);

		configure(MODE_RESTART, COUNT_W'(16));
		send_tick(16'd0, 1'b0);
		send_tick(16'd13107, 1'b0);
		send_tick(16'd13107, 1'b0);
		send_item(CMD_UNKNOWN, 16'hFFFF, 1'b1, 1'b1, 4'hF);
		send_level(1'b0);
		send_level(1'b1);
		send_tick(16'd100, 1'b0);
		send_tick(16'hFFFF, 1'b0);
		send_tick(16'd5, 1'b1);

		// With output gated off the index still walks.
		configure(MODE_RUN_WHILE_HIGH, COUNT_W'(16));
		send_level(1'b0);
		send_tick(16'd30000, 1'b0);
		send_tick(16'd10, 1'b0);
		send_level(1'b1);
		send_tick(16'd20000, 1'b0);

		// Lowering the count leaves the index past the end until the next wrap.
		configure(MODE_RUN_WHILE_HIGH, COUNT_W'(3));
		send_tick(16'd40000, 1'b0);
		send_tick(16'd39000, 1'b0);
		send_tick(16'hFFFF, 1'b0);

		configure(MODE_RESTART_RUN, COUNT_W'(31));
		send_level(1'b0);
		send_level(1'b1);
		send_tick(16'd0, 1'b1);
		send_tick(16'hFFFF, 1'b0);

		configure(MODE_ONE_SHOT, COUNT_W'(17));
		send_level(1'b0);
		send_level(1'b1);
		clock_pos = 0;

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			configure(phase_mode[ph], COUNT_W'(phase_count[ph]));
			send_idle_pct = send_profile[ph % 4];
			recv_stall_pct = recv_profile[ph % 4];
			// The receiver goes quiet while items keep coming, so the block backs up.
			if (ph == 0)
				hold_request = HOLD_OFF_CYCLES;
			sent = 0;
			paused = 1'b0;
			if (ph % 3 == 1) begin
				load_pattern();
				sent += MAX_TRIGS;
			end
			while (sent < PHASE_ITEMS) begin
				if (ph == 5 && !paused && sent >= PHASE_ITEMS / 2) begin
					drain_results();
					paused = 1'b1;
				end
				r = $urandom_range(0, 99);
				if (r < 2) begin
					load_pattern();
					sent += MAX_TRIGS;
				end else begin
					if (r < 62)
						send_pattern_tick();
					else if (r < 72)
						send_level($urandom_range(0, 99) < 60);
					else if (r < 80)
						send_item(CMD_WRITE, POS_W'($urandom_range(0, POS_SPAN - 1)),
							1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
							SLOT_W'($urandom_range(0, 15)));
					else if (r < 84)
						send_item(CMD_UNKNOWN, POS_W'($urandom_range(0, POS_SPAN - 1)),
							1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
							SLOT_W'($urandom_range(0, 15)));
					else begin
						clock_pos = $urandom_range(0, POS_SPAN - 1);
						send_tick(clock_pos[POS_W-1:0], 1'($urandom_range(0, 1)));
					end
					sent++;
				end
			end
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;
		drain_results();
		repeat (DRAIN_MARGIN) @(posedge clk);

		$display("Covered %0d ticks, %0d reset events, %0d table writes, %0d unknown commands",
			sb.cmd_seen[CMD_TICK], sb.cmd_seen[CMD_RESET_EVT], sb.cmd_seen[CMD_WRITE],
			sb.cmd_seen[CMD_UNKNOWN]);
		$display("Checked %0d results: %0d trigger pulses, %0d restart requests, %0d mismatches",
			sb.results_checked, sb.pulses_checked, sb.restarts_checked, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending_pulses.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
